// File: sv/gww_pkg.sv
package gww_pkg;

    // Word store depth and the derived widths
    localparam int MAX_WORD = 32;
    localparam int CNT_W    = $clog2(MAX_WORD + 1);
    localparam int IDX_W    = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam int POS_W    = 8;
    localparam int LEN_W    = 7;

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_SPACE = 8'd32;

    localparam logic [LEN_W-1:0] LINE_LEN_RESET = 7'd16;
    localparam logic [POS_W-1:0] POS_MAX        = 8'd255;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_WORD,
        ST_TAIL
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // input transfer this cycle
        logic load_nl;    // emit newline
        logic load_word;  // emit stored byte at the word index
        logic load_tail;  // emit trailing space or closing zero
        logic clear_idx;
        logic inc_idx;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_close;  // incoming byte closes a word
        logic wrap;        // line position plus word length exceeds line length
        logic count_zero;
        logic idx_at_end;
        logic out_free;    // output register can take a byte this cycle
    } ctrl_sts_t;

endpackage

// File: sv/greedy_word_wrap.sv
// Greedy word wrap over a byte stream.
// Input channel s_*: one text byte per transfer, s_tlast marks the last byte
// of the text buffer. A space (32) closes a word; a zero byte or the s_tlast
// byte closes the last word of the text.
// Output channel m_*: wrapped text. A closed word gives an optional newline,
// its stored bytes, then a space, or the closing zero (m_tuser high) at the
// end of the text. m_tlast marks the last byte caused by one input transfer.
// cfg_wen/cfg_wdata set the line length; write it only while the block idles.
// Throughput: a byte that only extends a word is accepted one per cycle. A
// closing byte goes through the newline-test state (optional newline), the
// word state, which replays the stored bytes one per cycle while the output
// is not stalled, and the tail state (trailing space or zero). The first
// output byte is the newline if due, else a word byte or the tail byte.
// s_tready is low while a word is replayed.
// Reset: line length returns to 16, word and line position clear, output
// empties. A stalled m_tready holds the output register and the replay.
module greedy_word_wrap (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wen,
    input  logic [6:0] cfg_wdata,   // line_length
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] text_byte
    input  logic       s_tlast,     // is_final
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [7:0] out_byte
    output logic       m_tlast,     // run_last
    output logic       m_tuser      // [0] text_done
);

    gww_pkg::ctrl_cmd_t cmd;
    gww_pkg::ctrl_sts_t sts;

    gww_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gww_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// File: sv/gww_ctrl.sv
module gww_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  gww_pkg::ctrl_sts_t   sts,
    output gww_pkg::ctrl_cmd_t   cmd
);

    gww_pkg::state_t state_reg;
    gww_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gww_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gww_pkg::ST_IDLE: begin
                if (s_tvalid && sts.need_close) begin
                    state_next = gww_pkg::ST_CLOSE;
                end
            end
            gww_pkg::ST_CLOSE: begin
                if (!sts.wrap || sts.out_free) begin
                    state_next = sts.count_zero ? gww_pkg::ST_TAIL : gww_pkg::ST_WORD;
                end
            end
            gww_pkg::ST_WORD: begin
                if (sts.out_free && sts.idx_at_end) begin
                    state_next = gww_pkg::ST_TAIL;
                end
            end
            gww_pkg::ST_TAIL: begin
                if (sts.out_free) begin
                    state_next = gww_pkg::ST_IDLE;
                end
            end
            default: state_next = gww_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            gww_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            gww_pkg::ST_CLOSE: begin
                cmd.clear_idx = 1'b1;
                cmd.load_nl   = sts.wrap && sts.out_free;
            end
            gww_pkg::ST_WORD: begin
                cmd.load_word = sts.out_free;
                cmd.inc_idx   = sts.out_free && !sts.idx_at_end;
            end
            gww_pkg::ST_TAIL: begin
                cmd.load_tail = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: sv/gww_dp.sv
module gww_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wen,
    input  logic [6:0]           cfg_wdata,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser,
    input  gww_pkg::ctrl_cmd_t   cmd,
    output gww_pkg::ctrl_sts_t   sts
);

    logic [7:0]                  store_mem [gww_pkg::MAX_WORD];
    logic [gww_pkg::CNT_W-1:0]   count_reg;
    logic [gww_pkg::POS_W-1:0]   pos_reg;
    logic [gww_pkg::LEN_W-1:0]   len_reg;
    logic                        skip_reg;
    logic                        last_reg;
    logic [gww_pkg::IDX_W-1:0]   idx_reg;
    logic                        valid_reg;
    logic [7:0]                  data_reg;
    logic                        tlast_reg;
    logic                        done_reg;

    logic                        in_zero;
    logic                        in_space;
    logic                        store_en;
    logic [gww_pkg::POS_W:0]     pos_sum;
    logic [gww_pkg::POS_W:0]     pos_tail;
    logic [gww_pkg::CNT_W-1:0]   idx_plus1;

    // Input byte classes
    assign in_zero  = (s_tdata == gww_pkg::CHAR_NUL);
    assign in_space = (s_tdata == gww_pkg::CHAR_SPACE);
    assign store_en = cmd.accept && !skip_reg && !in_zero && !in_space &&
                      (count_reg < gww_pkg::CNT_W'(gww_pkg::MAX_WORD));

    // Newline test and position arithmetic
    assign pos_sum   = {1'b0, pos_reg} + (gww_pkg::POS_W + 1)'(count_reg);
    assign pos_tail  = pos_sum + 1'b1;
    assign idx_plus1 = gww_pkg::CNT_W'(idx_reg) + 1'b1;

    assign sts.need_close = !skip_reg && (in_zero || in_space || s_tlast);
    assign sts.wrap       = pos_sum > (gww_pkg::POS_W + 1)'(len_reg);
    assign sts.count_zero = (count_reg == '0);
    assign sts.idx_at_end = (idx_plus1 == count_reg);
    assign sts.out_free   = !valid_reg || m_tready;

    // Word store: written at the fill count, read at the replay index
    always_ff @(posedge aclk) begin
        if (store_en) begin
            store_mem[count_reg[gww_pkg::IDX_W-1:0]] <= s_tdata;
        end
    end

    // Line length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= gww_pkg::LINE_LEN_RESET;
        end else if (cfg_wen) begin
            len_reg <= cfg_wdata;
        end
    end

    // Word and line state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pos_reg   <= '0;
            skip_reg  <= 1'b0;
        end else begin
            if (cmd.accept) begin
                if (skip_reg) begin
                    if (s_tlast) begin
                        skip_reg <= 1'b0;
                    end
                end else if (in_zero) begin
                    skip_reg <= !s_tlast;
                end
            end
            if (store_en) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.load_nl) begin
                pos_reg <= '0;
            end
            if (cmd.load_tail) begin
                count_reg <= '0;
                if (last_reg) begin
                    pos_reg <= '0;
                end else if (pos_tail > (gww_pkg::POS_W + 1)'(gww_pkg::POS_MAX)) begin
                    pos_reg <= gww_pkg::POS_MAX;
                end else begin
                    pos_reg <= pos_tail[gww_pkg::POS_W-1:0];
                end
            end
        end
    end

    // Close kind and replay index
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            last_reg <= in_zero || !in_space || s_tlast;
        end
        if (cmd.clear_idx) begin
            idx_reg <= '0;
        end else if (cmd.inc_idx) begin
            idx_reg <= idx_plus1[gww_pkg::IDX_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.load_nl || cmd.load_word || cmd.load_tail) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_nl) begin
            data_reg  <= gww_pkg::CHAR_LF;
            tlast_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else if (cmd.load_word) begin
            data_reg  <= store_mem[idx_reg];
            tlast_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else if (cmd.load_tail) begin
            data_reg  <= last_reg ? gww_pkg::CHAR_NUL : gww_pkg::CHAR_SPACE;
            tlast_reg <= 1'b1;
            done_reg  <= last_reg;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = tlast_reg;
    assign m_tuser  = done_reg;

endmodule

// File: sv/gww_checker.sv
module gww_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // Stalled output transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // Closing zero is a zero byte that ends the run
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == gww_pkg::CHAR_NUL))
        else $error("text_done on a bad byte");

    // A run ends on a space or the closing zero
    a_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata == gww_pkg::CHAR_SPACE) || m_tuser)
        else $error("run ends on a bad byte");

    // Output is empty after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind greedy_word_wrap gww_checker u_gww_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// File: tb/tb_greedy_word_wrap.sv
module tb_greedy_word_wrap;

    localparam int STALL_LIMIT = 4000;          // cycles with no transfer before giving up
    localparam int SETTLE_CYC  = gww_pkg::MAX_WORD + 8;  // longest word replay plus margin
    localparam int BATCH_ITEMS = 10;

    // How a generated text is terminated
    typedef enum int {
        END_NUL,       // zero byte marked final
        END_NUL_SKIP,  // zero byte, ignored bytes, then a final byte
        END_SPACE,     // space marked final
        END_CHAR       // word byte marked final
    } text_end_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } text_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       done;
    } wrap_byte_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wen;
    logic [6:0] cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    greedy_word_wrap dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    text_item_t text_q[$];          // bytes waiting to be sent
    wrap_byte_t expected_bytes[$];  // wrapped output still owed by the block

    int send_idle_pct;
    int recv_idle_pct;
    bit handed_off;                 // current s_ transfer completed at the last edge
    int pushed_cnt;
    int err_cnt;
    int n_in;
    int n_out;
    int n_texts;
    int n_wraps;
    int idle_cycles;
    wrap_byte_t want;

    // Wrapper state mirrored by the testbench
    logic [7:0]                word_buf [0:gww_pkg::MAX_WORD-1];
    int                        word_len;
    int                        line_pos;
    bit                        skipping;
    logic [gww_pkg::LEN_W-1:0] line_len;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic expect_byte(input logic [7:0] c, input logic done);
        wrap_byte_t wb;
        wb.ch       = c;
        wb.run_last = 1'b0;
        wb.done     = done;
        expected_bytes.push_back(wb);
    endtask

    task automatic bump_pos(input int k);
        line_pos = (line_pos + k > int'(gww_pkg::POS_MAX)) ? int'(gww_pkg::POS_MAX)
                                                            : line_pos + k;
    endtask

    // Close the buffered word: optional newline, the word, then space or end of text
    task automatic close_word(input bit last_word);
        if (line_pos + word_len > int'(line_len)) begin
            expect_byte(gww_pkg::CHAR_LF, 1'b0);
            line_pos = 0;
            n_wraps++;
        end
        for (int i = 0; i < word_len; i++)
            expect_byte(word_buf[i], 1'b0);
        bump_pos(word_len);
        word_len = 0;
        if (last_word) begin
            expect_byte(gww_pkg::CHAR_NUL, 1'b1);
            line_pos = 0;
            n_texts++;
        end else begin
            expect_byte(gww_pkg::CHAR_SPACE, 1'b0);
            bump_pos(1);
        end
    endtask

    // Work out the output bytes caused by one accepted text byte
    task automatic predict_wrap(input logic [7:0] b, input logic fin);
        int owed_at_start;
        wrap_byte_t tail;
        owed_at_start = expected_bytes.size();
        if (skipping) begin
            if (fin)
                skipping = 1'b0;
        end else if (b == gww_pkg::CHAR_NUL) begin
            close_word(1'b1);
            if (!fin)
                skipping = 1'b1;
        end else if (b == gww_pkg::CHAR_SPACE) begin
            close_word(fin);
        end else begin
            if (word_len < gww_pkg::MAX_WORD) begin
                word_buf[word_len] = b;
                word_len++;
            end
            if (fin)
                close_word(1'b1);
        end
        // last byte of this run carries tlast
        if (expected_bytes.size() > owed_at_start) begin
            tail = expected_bytes.pop_back();
            tail.run_last = 1'b1;
            expected_bytes.push_back(tail);
        end
    endtask

    task automatic push_item(input logic [7:0] c, input logic fin);
        text_item_t it;
        it.ch  = c;
        it.fin = fin;
        text_q.push_back(it);
        pushed_cnt++;
    endtask

    function automatic logic [7:0] rand_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        if (c == gww_pkg::CHAR_SPACE)
            c = 8'h7E;
        return c;
    endfunction

    // One well-formed text: words with random content, a random way to end it
    task automatic gen_text();
        int words;
        int len;
        text_end_t how;
        words = $urandom_range(1, 3);
        for (int w = 0; w < words; w++) begin
            // now and then a word too long for the store
            if ($urandom_range(0, 14) == 0)
                len = $urandom_range(gww_pkg::MAX_WORD + 1, gww_pkg::MAX_WORD + 8);
            else
                len = $urandom_range(0, 9);
            for (int k = 0; k < len; k++)
                push_item(rand_char(), 1'b0);
            if (w < words - 1) begin
                push_item(gww_pkg::CHAR_SPACE, 1'b0);
                if ($urandom_range(0, 4) == 0)
                    push_item(gww_pkg::CHAR_SPACE, 1'b0);
            end
        end
        how = text_end_t'($urandom_range(0, 3));
        case (how)
            END_NUL: begin
                push_item(gww_pkg::CHAR_NUL, 1'b1);
            end
            END_NUL_SKIP: begin
                push_item(gww_pkg::CHAR_NUL, 1'b0);
                repeat ($urandom_range(0, 3))
                    push_item(8'($urandom_range(0, 255)), 1'b0);
                push_item(8'($urandom_range(0, 255)), 1'b1);
            end
            END_SPACE: begin
                push_item(gww_pkg::CHAR_SPACE, 1'b1);
            end
            default: begin
                push_item(rand_char(), 1'b1);
            end
        endcase
    endtask

    task automatic wait_drained();
        while (text_q.size() != 0 || s_tvalid || expected_bytes.size() != 0)
            @(negedge aclk);
    endtask

    // Mostly clean texts, with a few stray bytes in front of some of them
    task automatic run_batch(input int n_items, input bit pause_midway);
        int start;
        bit paused;
        start  = pushed_cnt;
        paused = 1'b0;
        while (pushed_cnt - start < n_items) begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 2))
                    push_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
            gen_text();
            // let the output side catch up completely before going on
            if (pause_midway && !paused && pushed_cnt - start >= n_items / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    // Register write only once the block has gone quiet
    task automatic set_line_length(input logic [6:0] v);
        wait_drained();
        repeat (SETTLE_CYC) @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    // Input driver and output ready, both moving on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || handed_off) begin
                handed_off = 1'b0;
                if (text_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= text_q[0].ch;
                    s_tlast  <= text_q[0].fin;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: config, input transfers into the predictor, output checks, watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wen)
                line_len = cfg_wdata;
            if (s_tvalid && s_tready) begin
                predict_wrap(s_tdata, s_tlast);
                void'(text_q.pop_front());
                handed_off = 1'b1;
                n_in++;
            end
            if (m_tvalid && m_tready) begin
                n_out++;
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected output byte 0x%02h", m_tdata));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.ch)
                        report_mismatch($sformatf("byte %0d: data 0x%02h, want 0x%02h",
                                                  n_out, m_tdata, want.ch));
                    if (m_tlast !== want.run_last)
                        report_mismatch($sformatf("byte %0d: tlast %b, want %b",
                                                  n_out, m_tlast, want.run_last));
                    if (m_tuser !== want.done)
                        report_mismatch($sformatf("byte %0d: tuser %b, want %b",
                                                  n_out, m_tuser, want.done));
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d bytes still owed",
                     STALL_LIMIT, expected_bytes.size());
            $display("[greedy_word_wrap] ERROR");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        s_tvalid      = 1'b0;
        s_tdata       = 8'd0;
        s_tlast       = 1'b0;
        m_tready      = 1'b0;
        cfg_wen       = 1'b0;
        cfg_wdata     = 7'd0;
        aresetn       = 1'b0;
        handed_off    = 1'b0;
        pushed_cnt    = 0;
        err_cnt       = 0;
        n_in          = 0;
        n_out         = 0;
        n_texts       = 0;
        n_wraps       = 0;
        idle_cycles   = 0;
        word_len      = 0;
        line_pos      = 0;
        skipping      = 1'b0;
        line_len      = gww_pkg::LINE_LEN_RESET;
        send_idle_pct = 36;
        recv_idle_pct = 65;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed, at the reset line length
        push_item("A", 1'b0);                  // plain word and its space
        push_item("B", 1'b0);
        push_item(gww_pkg::CHAR_SPACE, 1'b0);
        push_item(gww_pkg::CHAR_SPACE, 1'b0);  // empty word
        push_item(8'hFF, 1'b0);                // high-bit bytes in a word
        push_item(8'h7F, 1'b0);
        push_item(8'h80, 1'b0);
        push_item(gww_pkg::CHAR_SPACE, 1'b0);
        push_item("C", 1'b1);                  // word byte marked final
        push_item("D", 1'b0);
        push_item(gww_pkg::CHAR_NUL, 1'b0);    // zero ends text, rest skipped
        push_item("E", 1'b0);
        push_item(gww_pkg::CHAR_NUL, 1'b0);
        push_item("F", 1'b1);                  // final byte clears the skip
        push_item(gww_pkg::CHAR_SPACE, 1'b1);  // final space: empty last word
        push_item(gww_pkg::CHAR_NUL, 1'b1);    // zero marked final
        push_item(8'h01, 1'b0);
        push_item(8'hFE, 1'b1);

        set_line_length(7'd1);
        run_batch(BATCH_ITEMS, 1'b0);

        send_idle_pct = 65;
        recv_idle_pct = 36;
        set_line_length(7'd127);
        run_batch(BATCH_ITEMS, 1'b1);
        set_line_length(7'd0);
        run_batch(BATCH_ITEMS, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_line_length(7'd64);
        run_batch(BATCH_ITEMS, 1'b0);
        set_line_length(7'd10);
        run_batch(BATCH_ITEMS, 1'b0);

        wait_drained();
        repeat (SETTLE_CYC) @(negedge aclk);
        if (expected_bytes.size() != 0)
            report_mismatch($sformatf("%0d expected bytes never arrived",
                                      expected_bytes.size()));

        $display("covered %0d input bytes, %0d output bytes, %0d texts, %0d line breaks",
                 n_in, n_out, n_texts, n_wraps);
        $display("line lengths 16, 1, 127, 0, 64, 10 under three stall profiles; %0d errors",
                 err_cnt);
        if (err_cnt == 0)
            $display("[greedy_word_wrap] OK");
        else
            $display("[greedy_word_wrap] ERROR");
        $finish;
    end

endmodule
